@@ rtl/core/base64_decoder_macros.svh @@
// Assertion macros used by the Base64 decoder checker.
`ifndef BASE64_DECODER_MACROS_SVH
`define BASE64_DECODER_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define B64_ASSERT_NOW(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("b64 checker: same-cycle property failed");

// Next-cycle implication, ignored while reset is high.
`define B64_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("b64 checker: next-cycle property failed");

`endif

@@ rtl/core/b64_pkg.sv @@
// Types, constants and the alphabet lookup shared by the Base64 decoder.
package b64_pkg;

   // Sextets held before the fourth character of a group arrives
   localparam int HeldDepth = 3;
   localparam int HeldIdxWidth = $clog2(HeldDepth);

   // Group queue between front and back; depth must be a power of two
   localparam int QueueDepth = 2;
   localparam int QueuePtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   // Characters of note
   localparam logic [7:0] EqualsChar = 8'h3d;
   localparam logic [7:0] PlusChar   = 8'h2b;
   localparam logic [7:0] SlashChar  = 8'h2f;

   // One decoded group waiting to be serialized
   typedef struct packed {
      logic [2:0][7:0] data;        // data[0] goes out first
      logic [1:0]      count;       // bytes to emit, 1 to 3
      logic            stream_end;  // group closes the string
   } group_type;

   // Queue status seen by the front and the back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Standard alphabet; anything else decodes as zero
   function automatic logic [5:0] sextet_of(input logic [7:0] c);
      logic [7:0] diff;
      diff = 8'h00;
      if (c >= 8'h41 && c <= 8'h5a) begin
         diff = c - 8'h41;
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         diff = c - 8'h47;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         diff = c + 8'h04;
      end else if (c == PlusChar) begin
         diff = 8'd62;
      end else if (c == SlashChar) begin
         diff = 8'd63;
      end
      return diff[5:0];
   endfunction

endpackage

@@ rtl/core/b64_front.sv @@
// Front end: takes characters, decodes sextets and assembles byte groups.
module b64_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_in_char,
   input  logic                        req_in_last,
   input  b64_pkg::queue_status_type   q_status,
   output logic                        push_valid,
   output b64_pkg::group_type          push_group
);

   logic [1:0] pos_ff, pos_in;
   logic [1:0] run_ff, run_in;
   logic [5:0] held_ff [0:b64_pkg::HeldDepth-1];

   logic       accept;
   logic [5:0] sextet;
   logic [1:0] run_upd;
   logic [1:0] count;
   logic       group_done;

   // Only the closing character of a group needs queue space
   assign req_stall  = q_status.full && (pos_ff == 2'd3);
   assign accept     = req_valid && !req_stall;
   assign sextet     = b64_pkg::sextet_of(req_in_char);
   assign group_done = (pos_ff == 2'd3);

   // Trailing '=' run and byte count of a finished group
   always_comb begin
      if (pos_ff == 2'd0) begin
         run_upd = 2'd0;
      end else if (req_in_char == b64_pkg::EqualsChar) begin
         run_upd = run_ff + 2'd1;
      end else begin
         run_upd = 2'd0;
      end
      count = req_in_last ? (2'd3 - run_upd) : 2'd3;
   end

   // Group word pushed into the queue
   always_comb begin
      push_group.data[0]    = {held_ff[0], held_ff[1][5:4]};
      push_group.data[1]    = {held_ff[1][3:0], held_ff[2][5:2]};
      push_group.data[2]    = {held_ff[2][1:0], sextet};
      push_group.count      = count;
      push_group.stream_end = req_in_last;
      push_valid            = accept && group_done && (count != 2'd0);
   end

   // Position and run update; end of string restarts both
   always_comb begin
      pos_in = pos_ff;
      run_in = run_ff;
      if (accept) begin
         run_in = run_upd;
         pos_in = group_done ? 2'd0 : pos_ff + 2'd1;
         if (req_in_last) begin
            pos_in = 2'd0;
            run_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 2'd0;
         run_ff <= 2'd0;
      end else begin
         pos_ff <= pos_in;
         run_ff <= run_in;
      end
   end

   // Sextet store for positions 0..2
   always_ff @(posedge clock) begin
      if (accept && !group_done) begin
         held_ff[pos_ff[b64_pkg::HeldIdxWidth-1:0]] <= sextet;
      end
   end

endmodule

@@ rtl/core/b64_queue.sv @@
// Short group queue that decouples the front end from the serializer.
module b64_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   input  b64_pkg::group_type          push_group,
   input  logic                        pop,
   output b64_pkg::group_type          head_group,
   output b64_pkg::queue_status_type   q_status
);

   b64_pkg::group_type entries_ff [0:b64_pkg::QueueDepth-1];

   logic [b64_pkg::QueuePtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [b64_pkg::QueuePtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [b64_pkg::QueueCountWidth-1:0] count_ff, count_in;
   logic                                do_push;
   logic                                do_pop;

   // Status and head word
   always_comb begin
      q_status.full  = (count_ff == b64_pkg::QueueCountWidth'(b64_pkg::QueueDepth));
      q_status.empty = (count_ff == '0);
      head_group     = entries_ff[rd_ptr_ff];
   end

   assign do_push = push_valid && !q_status.full;
   assign do_pop  = pop && !q_status.empty;

   // Pointer and fill update; pointers wrap on the power-of-two depth
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_group;
      end
   end

endmodule

@@ rtl/core/b64_back.sv @@
// Back end: serializes queued groups into bytes through an output register.
module b64_back (
   input  logic                        clock,
   input  logic                        reset,
   input  b64_pkg::group_type          head_group,
   input  b64_pkg::queue_status_type   q_status,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_out_group_last,
   output logic                        rsp_out_stream_end
);

   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic [7:0] byte_ff;
   logic       group_last_ff;
   logic       stream_end_ff;

   logic       load;
   logic       last_of_group;

   // Output register takes a new word when empty or being drained
   assign load          = !q_status.empty && (!valid_ff || !rsp_stall);
   assign last_of_group = (idx_ff == head_group.count - 2'd1);
   assign pop           = load && last_of_group;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = last_of_group ? 2'd0 : idx_ff + 2'd1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   // Output word
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff       <= head_group.data[idx_ff];
         group_last_ff <= last_of_group;
         stream_end_ff <= last_of_group && head_group.stream_end;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_out_byte       = byte_ff;
   assign rsp_out_group_last = group_last_ff;
   assign rsp_out_stream_end = stream_end_ff;

endmodule

@@ rtl/core/base64_decoder.sv @@
// Top level of the streaming Base64 decoder.
// Takes one character per cycle unless req_stall holds it, and gives one
// decoded byte per cycle unless rsp_stall holds it. Each fourth character
// of a group closes it and places up to three bytes in a two-entry group
// queue; the serializer drains them one a cycle while rsp_stall is low,
// through an output register, so four characters in and three bytes out keep
// pace. The first byte of a group passes through the group queue and then the
// output register before it is shown. req_stall rises only for a closing
// character when the group queue is full. A final group with a trailing '='
// run gives fewer bytes, a partial group at the end of the string gives
// none, and the last byte of the string carries rsp_out_stream_end.
module base64_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_char,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_group_last,
   output logic       rsp_out_stream_end
);

   b64_pkg::queue_status_type q_status;
   b64_pkg::group_type        push_group;
   b64_pkg::group_type        head_group;
   logic                      push_valid;
   logic                      pop;

   b64_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_char (req_in_char),
      .req_in_last (req_in_last),
      .q_status    (q_status),
      .push_valid  (push_valid),
      .push_group  (push_group)
   );

   b64_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_group (push_group),
      .pop        (pop),
      .head_group (head_group),
      .q_status   (q_status)
   );

   b64_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_group         (head_group),
      .q_status           (q_status),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_out_group_last (rsp_out_group_last),
      .rsp_out_stream_end (rsp_out_stream_end)
   );

endmodule

@@ rtl/core/b64_checker.sv @@
// Port-level checks for the Base64 decoder and their binding to the top level.
`include "base64_decoder_macros.svh"

module b64_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_in_char,
   input logic       req_in_last,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_group_last,
   input logic       rsp_out_stream_end
);

   // A stalled result word stays valid
   `B64_ASSERT_NEXT(rsp_hold_valid, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // A stalled result word keeps its byte
   `B64_ASSERT_NEXT(rsp_hold_byte, clock, reset, rsp_valid && rsp_stall, $stable(rsp_out_byte))

   // End of string only ever closes a group
   `B64_ASSERT_NOW(end_closes_group, clock, reset, rsp_valid && rsp_out_stream_end, rsp_out_group_last)

   // Nothing is shown the cycle after reset
   `B64_ASSERT_NOW(quiet_after_reset, clock, reset, $past(reset), !rsp_valid)

endmodule

bind base64_decoder b64_checker u_b64_checker (.*);
